@@ sv/bfes_pkg.sv @@
// Package for the bounded FIFO-eviction set: sizes, request codes, types
// and field conversion helpers. No dependencies.
package bfes_pkg;

    localparam int DEPTH       = 8;
    localparam int VALUE_WIDTH = 32;

    // Fixed field widths of the request and response words
    localparam int REQ_TYPE_W  = 2;
    localparam int ELEMENT_W   = 32;
    localparam int HIT_POS_W   = 3;
    localparam int ENTRY_CNT_W = 4;

    localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    // Request codes; every other code acts as a lookup
    localparam logic [REQ_TYPE_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE = 2'd1;

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [POS_W-1:0]       t_pos;
    typedef logic [CNT_W-1:0]       t_count;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic add_miss;  // push the key in at the front
        logic remove;    // close the gap behind a match
    } t_cell_ctl;

    // Result of the priority search over the cell row
    typedef struct packed {
        logic hit;
        t_pos pos;
    } t_match;

    typedef struct packed {
        logic                   hit;
        logic [HIT_POS_W-1:0]   hit_position;
        logic [ENTRY_CNT_W-1:0] entry_count;
        logic                   evicted;
        logic [ELEMENT_W-1:0]   evicted_value;
    } t_rsp;

    function automatic t_value field_to_value(logic [ELEMENT_W-1:0] f);
        logic [63:0] wide;
        wide = 64'(f);
        return wide[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic [ELEMENT_W-1:0] value_to_field(t_value v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[ELEMENT_W-1:0];
    endfunction

    function automatic logic [HIT_POS_W-1:0] pos_to_field(t_pos p);
        logic [63:0] wide;
        wide = 64'(p);
        return wide[HIT_POS_W-1:0];
    endfunction

    function automatic logic [ENTRY_CNT_W-1:0] count_to_field(t_count c);
        logic [63:0] wide;
        wide = 64'(c);
        return wide[ENTRY_CNT_W-1:0];
    endfunction

endpackage

@@ sv/bfes_if.sv @@
// Valid/ready channel interfaces for request and response words.
// Depends on bfes_pkg for field widths.
interface bfes_req_if;
    logic                                valid;
    logic                                ready;
    logic [bfes_pkg::REQ_TYPE_W-1:0]     req_type;
    logic [bfes_pkg::ELEMENT_W-1:0]      element_value;

    modport source (output valid, output req_type, output element_value, input ready);
    modport sink   (input valid, input req_type, input element_value, output ready);
endinterface

interface bfes_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic [bfes_pkg::HIT_POS_W-1:0]      hit_position;
    logic [bfes_pkg::ENTRY_CNT_W-1:0]    entry_count;
    logic                                evicted;
    logic [bfes_pkg::ELEMENT_W-1:0]      evicted_value;

    modport source (output valid, output hit, output hit_position, output entry_count,
                    output evicted, output evicted_value, input ready);
    modport sink   (input valid, input hit, input hit_position, input entry_count,
                    input evicted, input evicted_value, output ready);
endinterface

@@ sv/bounded_fifo_evict_set.sv @@
// Top level of the bounded FIFO-eviction associative set: a row of cells,
// the match encoder, the entry counter and the response register.
// Depends on bfes_pkg, bfes_if, bfes_cell and bfes_pos_enc.
//
//  channel   modport         direction  payload
//  i_req     bfes_req_if     in         req_type, element_value
//  o_rsp     bfes_rsp_if     out        hit, hit_position, entry_count,
//                                       evicted, evicted_value
//
// Each request word is handled by the compare-and-shift: all cells compare against
// the key in parallel, the priority encoder picks the newest match and the row
// shifts at the same edge. The response word is registered and shows in the cycle
// after acceptance; a request is taken every cycle while that register is empty or
// draining, so a stalled response holds the request side. Reset clears valid bits,
// count and response valid; values stay.
module bounded_fifo_evict_set (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bfes_req_if.sink      i_req,
    bfes_rsp_if.source    o_rsp
);

    localparam int D = bfes_pkg::DEPTH;

    bfes_pkg::t_value    w_key;
    bfes_pkg::t_cell_ctl w_ctl;
    bfes_pkg::t_match    w_match;
    bfes_pkg::t_count    r_count;
    bfes_pkg::t_count    n_count;
    bfes_pkg::t_rsp      r_rsp;
    bfes_pkg::t_rsp      n_rsp;
    logic                r_rsp_valid;
    logic                w_accept;
    logic                w_full;

    bfes_pkg::t_value    w_value [D];
    logic [D-1:0]        w_valid;
    logic [D-1:0]        w_cell_match;
    logic [D:0]          w_seen;

    // Take a request whenever the response register is free or draining
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_key  = bfes_pkg::field_to_value(i_req.element_value);
    assign w_full = (r_count == bfes_pkg::FULL_COUNT);

    // Drive the row: push the key on an add that misses, close the gap on
    // a remove (cells behind the match shift forward; a miss shifts none)
    assign w_ctl.add_miss = w_accept && (i_req.req_type == bfes_pkg::REQ_ADD) && !w_match.hit;
    assign w_ctl.remove   = w_accept && (i_req.req_type == bfes_pkg::REQ_REMOVE);

    assign w_seen[0] = 1'b0;

    for (genvar g = 0; g < D; g++) begin : g_cell
        bfes_pkg::t_value prev_value;
        logic             prev_valid;
        bfes_pkg::t_value next_value;
        logic             next_valid;

        if (g == 0) begin : g_front
            assign prev_value = w_key;
            assign prev_valid = 1'b1;
        end else begin : g_inner_prev
            assign prev_value = w_value[g-1];
            assign prev_valid = w_valid[g-1];
        end

        if (g == D - 1) begin : g_back
            // Back cell empties on a remove that hits; its value is a don't care
            assign next_value = w_value[g];
            assign next_valid = 1'b0;
        end else begin : g_inner_next
            assign next_value = w_value[g+1];
            assign next_valid = w_valid[g+1];
        end

        bfes_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_key        (w_key),
            .i_prev_value (prev_value),
            .i_prev_valid (prev_valid),
            .i_next_value (next_value),
            .i_next_valid (next_valid),
            .i_seen       (w_seen[g]),
            .o_seen       (w_seen[g+1]),
            .o_match      (w_cell_match[g]),
            .o_value      (w_value[g]),
            .o_valid      (w_valid[g])
        );
    end

    bfes_pos_enc u_pos_enc (
        .i_match (w_cell_match),
        .o_match (w_match)
    );

    // Count after the operation: saturate on add, drop by one on a hit remove
    always_comb begin
        n_count = r_count;
        if (w_ctl.add_miss && !w_full) begin
            n_count = r_count + 1'b1;
        end else if (w_ctl.remove && w_match.hit) begin
            n_count = r_count - 1'b1;
        end
    end

    // Build the response word; the back cell is the one evicted when full
    always_comb begin
        n_rsp.hit           = w_match.hit;
        n_rsp.hit_position  = w_match.hit ? bfes_pkg::pos_to_field(w_match.pos) : '0;
        n_rsp.entry_count   = bfes_pkg::count_to_field(n_count);
        n_rsp.evicted       = w_ctl.add_miss && w_full;
        n_rsp.evicted_value = (w_ctl.add_miss && w_full)
                              ? bfes_pkg::value_to_field(w_value[D-1]) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.hit           = r_rsp.hit;
    assign o_rsp.hit_position  = r_rsp.hit_position;
    assign o_rsp.entry_count   = r_rsp.entry_count;
    assign o_rsp.evicted       = r_rsp.evicted;
    assign o_rsp.evicted_value = r_rsp.evicted_value;

endmodule

@@ sv/bfes_cell.sv @@
// One storage cell of the set: holds an entry, compares it to the key and
// shifts from a neighbor on add or remove. Depends on bfes_pkg.
module bfes_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bfes_pkg::t_cell_ctl i_ctl,
    input  bfes_pkg::t_value    i_key,
    input  bfes_pkg::t_value    i_prev_value,
    input  logic                i_prev_valid,
    input  bfes_pkg::t_value    i_next_value,
    input  logic                i_next_valid,
    input  logic                i_seen,
    output logic                o_seen,
    output logic                o_match,
    output bfes_pkg::t_value    o_value,
    output logic                o_valid
);

    bfes_pkg::t_value r_value;
    bfes_pkg::t_value n_value;
    logic             r_valid;
    logic             n_valid;

    assign o_match = r_valid && (r_value == i_key);
    // A match here or nearer the front puts this cell behind the gap
    assign o_seen  = i_seen || o_match;
    assign o_value = r_value;
    assign o_valid = r_valid;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.add_miss) begin
            n_value = i_prev_value;
            n_valid = i_prev_valid;
        end else if (i_ctl.remove && o_seen) begin
            n_value = i_next_value;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

@@ sv/bfes_pos_enc.sv @@
// Priority encoder over the cell match lines: first match from the front.
// Depends on bfes_pkg.
module bfes_pos_enc (
    input  logic [bfes_pkg::DEPTH-1:0] i_match,
    output bfes_pkg::t_match           o_match
);

    always_comb begin
        o_match.hit = |i_match;
        o_match.pos = '0;
        // Walk from the back so the newest match wins
        for (int i = bfes_pkg::DEPTH - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                o_match.pos = bfes_pkg::POS_W'(i);
            end
        end
    end

endmodule

@@ sv/bfes_checker.sv @@
// Port-level checks for the bounded FIFO-eviction set, bound to the top.
// Depends on bfes_pkg and the top level bounded_fifo_evict_set.
module bfes_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               i_ready,
    input logic                               i_hit,
    input logic [bfes_pkg::HIT_POS_W-1:0]     i_hit_position,
    input logic [bfes_pkg::ENTRY_CNT_W-1:0]   i_entry_count,
    input logic                               i_evicted,
    input logic [bfes_pkg::ELEMENT_W-1:0]     i_evicted_value
);

    localparam logic [bfes_pkg::ENTRY_CNT_W-1:0] FULL_FIELD =
        bfes_pkg::count_to_field(bfes_pkg::FULL_COUNT);

    // Stalled response word holds its hit flag, entry count and evicted value
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_hit) && $stable(i_entry_count)
                                && $stable(i_evicted_value))
        else $error("response word changed while stalled");

    // Eviction only happens on a miss that leaves the set full
    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_evicted |-> !i_hit && i_entry_count == FULL_FIELD)
        else $error("eviction without a full set");

    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_hit |-> i_hit_position == '0)
        else $error("nonzero position on a miss");

    a_no_evict_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_evicted |-> i_evicted_value == '0)
        else $error("evicted value without eviction");

endmodule

bind bounded_fifo_evict_set bfes_checker u_bfes_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_rsp.valid),
    .i_ready         (o_rsp.ready),
    .i_hit           (o_rsp.hit),
    .i_hit_position  (o_rsp.hit_position),
    .i_entry_count   (o_rsp.entry_count),
    .i_evicted       (o_rsp.evicted),
    .i_evicted_value (o_rsp.evicted_value)
);

@@ bench/tb_bounded_fifo_evict_set.sv @@
// Self-checking bench for bounded_fifo_evict_set: directed and random request words,
// with each response word checked in order against a shadow copy of the set.
// Depends on bfes_pkg, bfes_if and the RTL of the block.
module tb_bounded_fifo_evict_set;

    typedef logic [bfes_pkg::REQ_TYPE_W-1:0]  t_req_type;
    typedef logic [bfes_pkg::ELEMENT_W-1:0]   t_element;
    typedef logic [bfes_pkg::HIT_POS_W-1:0]   t_pos_field;
    typedef logic [bfes_pkg::ENTRY_CNT_W-1:0] t_cnt_field;

    // Request codes the package leaves unnamed: lookup and the spare code
    localparam t_req_type REQ_LOOKUP = 2'd2;
    localparam t_req_type REQ_SPARE  = 2'd3;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 8;
    localparam int POOL_SIZE    = 12;        // a bit more than DEPTH: hits and evictions both
    localparam int RUN_LIMIT    = 2_000_000; // time units, far beyond the slowest clean run
    localparam int DEPTH        = bfes_pkg::DEPTH;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bfes_req_if req_ch ();
    bfes_rsp_if rsp_ch ();

    bounded_fifo_evict_set DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Shadow set, newest first; only slots below shadow_count are meaningful
    bfes_pkg::t_value       shadow_vals [DEPTH];
    int                     shadow_count;
    bfes_pkg::t_rsp         pending_rsp [$];
    t_element               value_pool [POOL_SIZE];
    int                     error_count;
    int                     src_idle_pct;
    int                     sink_idle_pct;

    function automatic string rsp_text(bfes_pkg::t_rsp r);
        return $sformatf("hit=%0b pos=%0d count=%0d evicted=%0b value=%h",
                         r.hit, r.hit_position, r.entry_count, r.evicted, r.evicted_value);
    endfunction

    // Apply one accepted request word to the shadow set and return the response it owes.
    function automatic bfes_pkg::t_rsp apply_request(t_req_type op, t_element raw);
        bfes_pkg::t_value key;
        int               found;
        bfes_pkg::t_rsp   r;
        key   = bfes_pkg::t_value'(raw);
        found = -1;
        // Search only the valid entries and keep the newest match
        for (int i = 0; i < shadow_count; i++) begin
            if (found < 0 && shadow_vals[i] == key) found = i;
        end
        r     = '0;
        r.hit = (found >= 0);
        if (found >= 0) r.hit_position = t_pos_field'(found);
        if (op == bfes_pkg::REQ_ADD && found < 0) begin
            // Full set: drop the oldest entry off the back
            if (shadow_count == DEPTH) begin
                r.evicted       = 1'b1;
                r.evicted_value = t_element'(shadow_vals[DEPTH-1]);
            end
            for (int i = DEPTH - 1; i > 0; i--) shadow_vals[i] = shadow_vals[i-1];
            shadow_vals[0] = key;
            if (shadow_count < DEPTH) shadow_count++;
        end else if (op == bfes_pkg::REQ_REMOVE && found >= 0) begin
            // Close the gap behind the match
            for (int i = found; i < DEPTH - 1; i++) shadow_vals[i] = shadow_vals[i+1];
            shadow_count--;
        end
        // Lookup, the spare code, add of a present value and remove of an absent one
        // all fall through here and leave the set untouched
        r.entry_count = t_cnt_field'(shadow_count);
        return r;
    endfunction

    // Send one request word. Enter and leave on a falling edge; idle at random first,
    // with noise on the payload, then hold valid until the block takes the word.
    task automatic send_word(input t_req_type op, input t_element raw);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid         = 1'b0;
            req_ch.req_type      = t_req_type'($urandom);
            req_ch.element_value = $urandom;
            @(negedge i_clk);
        end
        req_ch.valid         = 1'b1;
        req_ch.req_type      = op;
        req_ch.element_value = raw;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        // Predict at acceptance so the shadow set tracks the accepted order
        pending_rsp.push_back(apply_request(op, raw));
        @(negedge i_clk);
    endtask

    // Stall the response side at random; change ready only on the falling edge.
    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Check every accepted response word against the oldest pending prediction.
    always @(posedge i_clk) begin
        bfes_pkg::t_rsp got;
        bfes_pkg::t_rsp want;
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got = '{hit: rsp_ch.hit, hit_position: rsp_ch.hit_position,
                    entry_count: rsp_ch.entry_count, evicted: rsp_ch.evicted,
                    evicted_value: rsp_ch.evicted_value};
            if (pending_rsp.size() == 0) begin
                error_count++;
                $display("%0t: response word with nothing pending: %s", $time, rsp_text(got));
            end else begin
                want = pending_rsp.pop_front();
                if (got !== want) begin
                    error_count++;
                    $display("%0t: mismatch expected %s actual %s",
                             $time, rsp_text(want), rsp_text(got));
                end
            end
        end
    end

    // Lookup and remove on an empty set: both miss, count stays at zero.
    task automatic test_empty_set();
        send_word(REQ_LOOKUP, 32'h0000_0000);
        send_word(bfes_pkg::REQ_REMOVE, 32'hFFFF_FFFF);
    endtask

    // Fill the set with extreme values, re-add a present one, probe the two oldest slots
    // with lookup and the spare code, then push past full to force two evictions.
    task automatic test_fill_and_evict();
        send_word(bfes_pkg::REQ_ADD, 32'h0000_0000);
        send_word(bfes_pkg::REQ_ADD, 32'hFFFF_FFFF);
        send_word(bfes_pkg::REQ_ADD, 32'h0000_0000);   // already present: hit, no shift
        send_word(bfes_pkg::REQ_ADD, 32'hA5A5_A5A5);
        send_word(bfes_pkg::REQ_ADD, 32'h5A5A_5A5A);
        send_word(bfes_pkg::REQ_ADD, 32'h0000_0001);
        send_word(bfes_pkg::REQ_ADD, 32'h0000_0002);
        send_word(bfes_pkg::REQ_ADD, 32'h0000_0003);
        send_word(bfes_pkg::REQ_ADD, 32'h8000_0000);   // set is full now
        send_word(REQ_LOOKUP,        32'h0000_0000);   // oldest slot
        send_word(REQ_SPARE,         32'hFFFF_FFFF);   // spare code behaves as lookup
        send_word(bfes_pkg::REQ_ADD, 32'h7FFF_FFFF);   // evicts the zero word
        send_word(bfes_pkg::REQ_ADD, 32'h1234_5678);   // evicts the all-ones word
    endtask

    // Remove from the middle, remove an absent value, remove the newest, then drain
    // from the oldest end until empty and look up once more.
    task automatic test_remove_paths();
        send_word(bfes_pkg::REQ_REMOVE, 32'h7FFF_FFFF);
        send_word(bfes_pkg::REQ_REMOVE, 32'h0000_0000);
        send_word(bfes_pkg::REQ_REMOVE, t_element'(shadow_vals[0]));
        while (shadow_count > 0) begin
            send_word(bfes_pkg::REQ_REMOVE, t_element'(shadow_vals[shadow_count-1]));
        end
        send_word(REQ_LOOKUP, 32'h8000_0000);
    endtask

    // Random traffic: values mostly from a small drifting pool or from the live set so
    // hits, evictions and removes are frequent; some fully random words toggle every bit.
    task automatic test_random_traffic(input int n_words);
        t_req_type op;
        t_element  raw;
        int        pick;
        repeat (n_words) begin
            if ($urandom_range(63) == 0) value_pool[$urandom_range(POOL_SIZE-1)] = $urandom;
            pick = $urandom_range(99);
            if (pick < 45)      op = bfes_pkg::REQ_ADD;
            else if (pick < 70) op = bfes_pkg::REQ_REMOVE;
            else if (pick < 95) op = REQ_LOOKUP;
            else                op = REQ_SPARE;
            pick = $urandom_range(99);
            if (pick < 10)
                raw = $urandom;
            else if (pick < 40 && shadow_count > 0)
                raw = t_element'(shadow_vals[$urandom_range(shadow_count-1)]);
            else
                raw = value_pool[$urandom_range(POOL_SIZE-1)];
            send_word(op, raw);
        end
    endtask

    initial begin
        req_ch.valid         = 1'b0;
        req_ch.req_type      = bfes_pkg::REQ_ADD;
        req_ch.element_value = '0;
        rsp_ch.ready         = 1'b0;
        error_count          = 0;
        shadow_count         = 0;
        src_idle_pct         = 20;
        sink_idle_pct        = 69;
        foreach (value_pool[i]) value_pool[i] = $urandom;

        // Hold reset, then release it on a falling edge
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_set();
        test_fill_and_evict();
        test_remove_paths();

        test_random_traffic(570);
        src_idle_pct  = 69;
        sink_idle_pct = 20;
        test_random_traffic(570);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_traffic(560);

        // Drop valid and wait out every pending response word
        req_ch.valid = 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: end a hung run
    initial begin
        #RUN_LIMIT;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
